// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds the data width, the operation codes, the sequencer states and the
// request and status structs that pass between the sequencer and the divider.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int W = 32;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_COMB,
		ST_GCD_GO,
		ST_GCD_WAIT,
		ST_QN_GO,
		ST_QN_WAIT,
		ST_QD_GO,
		ST_QD_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic         go;
		logic [W-1:0] dividend;
		logic [W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic         done;
		logic         busy;
		logic [W-1:0] quot;
		logic [W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: shared signed radix-2 divider
// Truncating signed divide and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rau_pkg::div_req_t req,
	output rau_pkg::div_rsp_t rsp
);
	import rau_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic          nq_q;
	logic          nr_q;

	logic [W-1:0]  ua;
	logic [W-1:0]  ub;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign ua = req.dividend[W-1] ? (~req.dividend + 1'b1) : req.dividend;
	assign ub = req.divisor[W-1] ? (~req.divisor + 1'b1) : req.divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= ua;
			dvs_q <= ub;
			nq_q  <= req.dividend[W-1] ^ req.divisor[W-1];
			nr_q  <= req.dividend[W-1];
		end else if (busy_q) begin
			// restoring step: shift in next dividend bit, try subtract
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quot = nq_q ? (~quo_q + 1'b1) : quo_q;
	assign rsp.rem  = nr_q ? (~rem_q + 1'b1) : rem_q;

`ifndef SYNTH
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("divider started while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a run");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("run ended without done");
`endif

endmodule

// ===== rtl/rational_arith_unit.sv =====
// rational_arith_unit: signed fraction add, subtract, multiply, divide with gcd reduction
// sequence: products, a combine step, euclid divides until the remainder is zero, a check,
//   two final divides by the gcd and done; each divide is issued, steps and ends in done
// throughput: one word at a time; busy stays high from start through the done strobe
// the result is shown for one cycle with done; the receiver cannot stall
// reset: arst_n asynchronous active low returns the sequencer to idle
// ----------------------------------------------------------------------------
// rational_arith_unit: top level
// Sequencer, shared multiplier and overflow tracking around the divider.
// ----------------------------------------------------------------------------
module rational_arith_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic signed [31:0]       a_num,
	input  logic signed [31:0]       a_den,
	input  logic signed [31:0]       b_num,
	input  logic signed [31:0]       b_den,
	output logic                     done,
	output logic signed [31:0]       res_num,
	output logic signed [31:0]       res_den,
	output logic                     overflow
);
	import rau_pkg::*;

	state_t       state_q, state_d;
	cmd_t         cmd_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic [W-1:0] p1_q, p2_q, num_q, den_q, g_q, b_q;
	logic         ov_q;
	logic [W-1:0] mx, my;
	logic [2*W-1:0] prod;
	logic         pov;
	logic [W:0]   sum;
	logic         sov;
	div_req_t     dreq;
	div_rsp_t     drsp;

	rau_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// one shared multiplier, operands picked by state
	always_comb begin
		mx = an_q;
		my = bd_q;
		case (state_q)
			ST_MUL1: begin
				mx = an_q;
				my = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			ST_MUL2: begin
				mx = (cmd_q == CMD_DIV) ? ad_q : bn_q;
				my = (cmd_q == CMD_DIV) ? bn_q : ad_q;
			end
			ST_MUL3: begin
				mx = ad_q;
				my = bd_q;
			end
			default: begin
				mx = an_q;
				my = bd_q;
			end
		endcase
	end

	assign prod = $signed(mx) * $signed(my);
	assign pov  = prod[2*W-1:W-1] != {(W+1){prod[W-1]}};
	assign sum  = (cmd_q == CMD_SUB) ? ({p1_q[W-1], p1_q} - {p2_q[W-1], p2_q})
	                                 : ({p1_q[W-1], p1_q} + {p2_q[W-1], p2_q});
	assign sov  = sum[W] != sum[W-1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_MUL1;
			ST_MUL1:     state_d = ST_MUL2;
			ST_MUL2:     state_d = ST_MUL3;
			ST_MUL3:     state_d = ST_COMB;
			ST_COMB:     state_d = ST_GCD_GO;
			ST_GCD_GO:   state_d = (b_q == '0) ? ST_QN_GO : ST_GCD_WAIT;
			ST_GCD_WAIT: if (drsp.done) state_d = ST_GCD_GO;
			ST_QN_GO:    state_d = ST_QN_WAIT;
			ST_QN_WAIT:  if (drsp.done) state_d = ST_QD_GO;
			ST_QD_GO:    state_d = ST_QD_WAIT;
			ST_QD_WAIT:  if (drsp.done) state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.go       = 1'b0;
		dreq.dividend = g_q;
		dreq.divisor  = b_q;
		case (state_q)
			ST_GCD_GO: dreq.go = (b_q != '0);
			ST_QN_GO: begin
				dreq.go       = 1'b1;
				dreq.dividend = num_q;
				dreq.divisor  = g_q;
			end
			ST_QD_GO: begin
				dreq.go       = 1'b1;
				dreq.dividend = den_q;
				dreq.divisor  = g_q;
			end
			default: dreq.go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd_t'(command);
				an_q  <= a_num;
				bn_q  <= b_num;
				ad_q  <= (a_den == '0) ? W'(1) : a_den;
				bd_q  <= (b_den == '0) ? W'(1) : b_den;
				ov_q  <= 1'b0;
			end
			ST_MUL1: begin
				p1_q <= prod[W-1:0];
				ov_q <= ov_q | pov;
			end
			ST_MUL2: begin
				// multiply has no cross product here
				p2_q <= prod[W-1:0];
				ov_q <= ov_q | (pov & (cmd_q != CMD_MUL));
			end
			ST_MUL3: begin
				// divide takes its denominator from the second product
				den_q <= prod[W-1:0];
				ov_q  <= ov_q | (pov & (cmd_q != CMD_DIV));
			end
			ST_COMB: begin
				// divide: den is the second product, num the first
				if (cmd_q == CMD_ADD || cmd_q == CMD_SUB) begin
					num_q <= sum[W-1:0];
					ov_q  <= ov_q | sov;
				end else begin
					num_q <= p1_q;
				end
				if (cmd_q == CMD_DIV) begin
					den_q <= (p2_q == '0) ? W'(1) : p2_q;
					g_q   <= (p2_q == '0) ? W'(1) : p2_q;
					b_q   <= (cmd_q == CMD_DIV) ? p1_q : sum[W-1:0];
				end else begin
					den_q <= (den_q == '0) ? W'(1) : den_q;
					g_q   <= (den_q == '0) ? W'(1) : den_q;
					b_q   <= (cmd_q == CMD_MUL) ? p1_q : sum[W-1:0];
				end
			end
			ST_GCD_WAIT: if (drsp.done) begin
				g_q <= b_q;
				b_q <= drsp.rem;
			end
			ST_QN_WAIT: if (drsp.done) num_q <= drsp.quot;
			ST_QD_WAIT: if (drsp.done) den_q <= drsp.quot;
			default: ;
		endcase
	end

	assign busy     = state_q != ST_IDLE;
	assign done     = state_q == ST_DONE;
	assign res_num  = num_q;
	assign res_den  = den_q;
	assign overflow = ov_q;

`ifndef SYNTH
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == ST_MUL1) else $error("start not taken");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than a cycle");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.go |-> !drsp.busy) else $error("divider reused while busy");
	a_gcd_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QN_GO |-> g_q != '0) else $error("zero gcd");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the rational arithmetic unit
// Drives fraction words through the start/busy handshake, predicts the
// reduced fraction and wrap flag of each word, and checks each done strobe.
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [31:0] num;
	logic signed [31:0] den;
	logic               ovf;
} frac_res_t;

class frac_scoreboard;
	frac_res_t pending[$];
	int        errors;

	// signed Euclid with truncating remainder, 32-bit wrap
	static function frac_res_t reduce_op(rau_pkg::cmd_t op,
			logic signed [31:0] an, logic signed [31:0] ad,
			logic signed [31:0] bn, logic signed [31:0] bd);
		frac_res_t r;
		longint p1, p2, s, nx, dx;
		logic signed [31:0] n, d, g, b, t;
		logic ov;
		ov = 0;
		if (ad == 0) ad = 1;
		if (bd == 0) bd = 1;
		p1 = 0;
		p2 = 0;
		case (op)
			rau_pkg::CMD_MUL: begin
				p1 = longint'(an) * longint'(bn);
				nx = p1;
			end
			rau_pkg::CMD_DIV: begin
				p1 = longint'(an) * longint'(bd);
				nx = p1;
			end
			default: begin
				p1 = longint'(an) * longint'(bd);
				p2 = longint'(bn) * longint'(ad);
				if (p2 != longint'(int'(p2))) ov = 1;
			end
		endcase
		if (p1 != longint'(int'(p1))) ov = 1;
		if (op == rau_pkg::CMD_ADD || op == rau_pkg::CMD_SUB) begin
			s = (op == rau_pkg::CMD_ADD) ? longint'(int'(p1)) + longint'(int'(p2))
				: longint'(int'(p1)) - longint'(int'(p2));
			if (s != longint'(int'(s))) ov = 1;
			nx = s;
		end
		dx = (op == rau_pkg::CMD_DIV) ? longint'(ad) * longint'(bn)
			: longint'(ad) * longint'(bd);
		if (dx != longint'(int'(dx))) ov = 1;
		n = nx[31:0];
		d = dx[31:0];
		if (d == 0) d = 1;
		g = d;
		b = n;
		while (b != 0) begin
			t = (b == -1) ? 32'sd0 : g % b;
			g = b;
			b = t;
		end
		r.num = (g == -1) ? -n : n / g;
		r.den = (g == -1) ? -d : d / g;
		r.ovf = ov;
		return r;
	endfunction

	function void note_word(rau_pkg::cmd_t op, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
		pending.push_back(reduce_op(op, an, ad, bn, bd));
	endfunction

	function void check_result(logic signed [31:0] n, logic signed [31:0] d, logic o);
		frac_res_t e;
		if (pending.size() == 0) begin
			report_mismatch("result with nothing pending");
			return;
		end
		e = pending.pop_front();
		if (n !== e.num) report_mismatch($sformatf("res_num %0d exp %0d", n, e.num));
		if (d !== e.den) report_mismatch($sformatf("res_den %0d exp %0d", d, e.den));
		if (o !== e.ovf) report_mismatch($sformatf("overflow %0b exp %0b", o, e.ovf));
	endfunction

	function void report_mismatch(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endfunction
endclass

module tb;
	import rau_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] command = CMD_ADD;
	logic signed [31:0] a_num = 0, a_den = 0, b_num = 0, b_den = 0;
	logic busy, done, overflow;
	logic signed [31:0] res_num, res_den;
	int send_idle_pct;
	longint cycles;
	frac_scoreboard sb;

	rational_arith_unit u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("FAIL rational_arith_unit");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && done) sb.check_result(res_num, res_den, overflow);

	function automatic logic signed [31:0] pick_val();
		case ($urandom_range(0, 9))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2: return 0;
			3: return -1;
			4, 5: return $signed($urandom_range(0, 40)) - 20;
			6, 7: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(cmd_t op, logic signed [31:0] an, logic signed [31:0] ad,
			logic signed [31:0] bn, logic signed [31:0] bd);
		bit idle;
		idle = ($urandom_range(0, 99) < send_idle_pct);
		if (idle) start <= 0;
		while (idle) begin
			@(posedge clk);
			idle = ($urandom_range(0, 99) < send_idle_pct);
		end
		start <= 1;
		command <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
		sb.note_word(op, an, ad, bn, bd);
	endtask

	initial begin
		logic signed [31:0] ext[6];
		sb = new();
		send_idle_pct = 16;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		ext = '{32'sh80000000, 32'sh7fffffff, 0, -1, 1, 32'sh55aa33cc};
		for (int i = 0; i < 4; i++) begin
			send_word(cmd_t'(i), 1, 2, 1, 3);
			send_word(cmd_t'(i), ext[i], ext[i + 1], ext[i + 2], ext[5 - i]);
			send_word(cmd_t'(i), 0, 7, 0, 0);
			send_word(cmd_t'(i), 32'sh80000000, 1, -1, 1);
			send_word(cmd_t'(i), -6, 4, 9, -12);
		end
		send_word(CMD_DIV, 5, 3, 0, 7);
		send_word(CMD_MUL, 32'sh80000000, -1, 1, 1);
		send_word(CMD_SUB, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
		for (int i = 0; i < 370; i++) begin
			if (i == 120) send_idle_pct = 48;
			if (i == 240) send_idle_pct = 0;
			send_word(cmd_t'($urandom_range(0, 3)), pick_val(), pick_val(),
				pick_val(), pick_val());
		end
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS rational_arith_unit");
		else
			$display("FAIL rational_arith_unit");
		$finish;
	end
endmodule
